// ===== rtl/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, constants and the character filter for the rx line editor.
// ----------------------------------------------------------------------------
package rle_pkg;

	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 6;
	localparam int TDATA_W = 16;

	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SEND,
		ST_EMPTY
	} state_t;

	function automatic logic is_line_char(input logic [CHAR_W-1:0] c);
		logic ok;
		ok = (c == CH_SPACE) || (c == CH_DOT) || (c == CH_PLUS) ||
		     (c == CH_MINUS) || (c == CH_COLON) ||
		     (c >= CH_0 && c <= CH_9) ||
		     (c >= CH_UA && c <= CH_UZ) ||
		     (c >= CH_LA && c <= CH_LZ);
		return ok;
	endfunction

endpackage

// ===== rtl/rx_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// rx_line_editor_core
// Editable command-line buffer for received serial bytes.
// ----------------------------------------------------------------------------
// Each byte taken on the slave side edits the stored line: letters,
// digits, space, dot, plus, minus and colon are appended while the
// line holds fewer than LINE_CAPACITY-1 characters, backspace removes the
// last character, other bytes are ignored. A carriage return sends the line
// out on the master side, one item per character with tlast on the final
// one, or a single item with tuser set for an empty line, and then clears
// the line. Readout goes through the single read port of the line memory,
// whose data is registered, so each character passes a fetch state and a
// send state, and the send state waits out any output stall; tready stays
// low from the carriage return until the last item of the line is taken.
// No clearing pass is needed after reset.
module rx_line_editor_core #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rle_pkg::TDATA_W-1:0]   m_axis_tdata,  // [7:0] line_char, [13:8] line_length
	output logic                          m_axis_tlast,  // last_of_line
	output logic                          m_axis_tuser   // empty_line
);

	localparam int AW = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
	localparam logic [AW-1:0] LIMIT = AW'(LINE_CAPACITY - 1);

	rle_pkg::state_t state_q, state_d;

	logic [AW-1:0]               fill_q;
	logic [AW-1:0]               rd_idx_q;
	logic                        in_acc;
	logic                        out_acc;
	logic                        is_last;
	logic                        wr_en;
	logic                        rd_en;
	logic [rle_pkg::CHAR_W-1:0]  rd_data;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign is_last = (({1'b0, rd_idx_q} + (AW+1)'(1)) == {1'b0, fill_q});

	rle_line_ram #(
		.DEPTH (LINE_CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q),
		.wr_data (s_axis_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		m_axis_tlast  = 1'b0;
		m_axis_tuser  = 1'b0;
		m_axis_tdata  = '0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		unique case (state_q)
			rle_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_acc) begin
					if (s_axis_tdata == rle_pkg::CH_CR) begin
						state_d = (fill_q == '0) ? rle_pkg::ST_EMPTY : rle_pkg::ST_FETCH;
					end else if (rle_pkg::is_line_char(s_axis_tdata) && fill_q < LIMIT) begin
						wr_en = 1'b1;
					end
				end
			end
			rle_pkg::ST_FETCH: begin
				rd_en   = 1'b1;
				state_d = rle_pkg::ST_SEND;
			end
			rle_pkg::ST_SEND: begin
				m_axis_tvalid = 1'b1;
				m_axis_tlast  = is_last;
				m_axis_tdata  = {{(rle_pkg::TDATA_W - rle_pkg::LEN_W - rle_pkg::CHAR_W){1'b0}},
				                 rle_pkg::LEN_W'(fill_q), rd_data};
				if (out_acc) begin
					state_d = is_last ? rle_pkg::ST_IDLE : rle_pkg::ST_FETCH;
				end
			end
			rle_pkg::ST_EMPTY: begin
				m_axis_tvalid = 1'b1;
				m_axis_tlast  = 1'b1;
				m_axis_tuser  = 1'b1;
				if (out_acc) begin
					state_d = rle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rle_pkg::ST_IDLE;
			end
		endcase
	end

	// fill count and readout index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_idx_q <= '0;
		end else begin
			if (state_q == rle_pkg::ST_IDLE && in_acc) begin
				rd_idx_q <= '0;
				if (wr_en) begin
					fill_q <= fill_q + AW'(1);
				end else if (s_axis_tdata == rle_pkg::CH_BS && fill_q != '0) begin
					fill_q <= fill_q - AW'(1);
				end
			end else if (state_q == rle_pkg::ST_SEND && out_acc) begin
				if (is_last) begin
					fill_q <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while an item is pending");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && fill_q == '0))
		else $error("empty-line item malformed");

	a_send_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (fill_q != '0 && rd_idx_q < fill_q))
		else $error("readout index out of line");

	a_line_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (s_axis_tready && fill_q == '0))
		else $error("line not cleared after last item");

endmodule

// ===== rtl/rle_line_ram.sv =====
// ----------------------------------------------------------------------------
// rle_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rle_line_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [rle_pkg::CHAR_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [rle_pkg::CHAR_W-1:0] rd_data
);

	logic [rle_pkg::CHAR_W-1:0] mem_q [DEPTH];
	logic [rle_pkg::CHAR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== test/rx_line_editor_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_line_editor_core_tb
// Self-checking bench for the rx line editor core.
// ----------------------------------------------------------------------------
// Serial bytes go in on the slave stream and a shadow copy of the command
// line tracks every edit. Each carriage return turns the shadow line into a
// list of due output items, which the master stream must match in order.
// A directed opening covers the empty line, backspace on an empty line,
// ignored bytes and the edges of every character class. Random lines follow,
// with edits, noise and overfilled lines, under random gaps on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------
module rx_line_editor_core_tb;

	localparam int LINE_CAP     = 64;
	localparam int LINE_MAX     = LINE_CAP - 1;
	localparam int ITEM_TARGET  = 460;
	localparam int QUIET_AFTER  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * LINE_CAP + 20;
	localparam int STALL_LIMIT  = 3000;

	typedef struct packed {
		logic [rle_pkg::CHAR_W-1:0] ch;
		logic                       last;
		logic                       empty;
		logic [rle_pkg::LEN_W-1:0]  len;
	} line_item_t;

	function automatic bit takes_char(input logic [rle_pkg::CHAR_W-1:0] c);
		return c inside {rle_pkg::CH_SPACE, rle_pkg::CH_DOT, rle_pkg::CH_PLUS,
			rle_pkg::CH_MINUS, rle_pkg::CH_COLON,
			[rle_pkg::CH_0:rle_pkg::CH_9],
			[rle_pkg::CH_UA:rle_pkg::CH_UZ],
			[rle_pkg::CH_LA:rle_pkg::CH_LZ]};
	endfunction

	class console_line_scoreboard;
		logic [rle_pkg::CHAR_W-1:0] shadow_line [LINE_CAP];
		int unsigned                shadow_fill;
		line_item_t                 items_due [$];
		int unsigned                errors;

		function new();
			shadow_fill = 0;
			errors      = 0;
		endfunction

		function void take_rx_byte(input logic [rle_pkg::CHAR_W-1:0] c);
			line_item_t item;
			if (c == rle_pkg::CH_CR) begin
				if (shadow_fill == 0) begin
					item = '{ch: '0, last: 1'b1, empty: 1'b1, len: '0};
					items_due.push_back(item);
				end else begin
					for (int k = 0; k < shadow_fill; k++) begin
						item.ch    = shadow_line[k];
						item.last  = (k == shadow_fill - 1);
						item.empty = 1'b0;
						item.len   = rle_pkg::LEN_W'(shadow_fill);
						items_due.push_back(item);
					end
				end
				shadow_fill = 0;
			end else if (c == rle_pkg::CH_BS) begin
				if (shadow_fill > 0)
					shadow_fill--;
			end else if (takes_char(c) && shadow_fill < LINE_MAX) begin
				shadow_line[shadow_fill] = c;
				shadow_fill++;
			end
		endfunction

		function void check_line_item(input logic [rle_pkg::TDATA_W-1:0] data,
				input logic last, input logic empty);
			line_item_t want;
			if (items_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected line item, expected none, actual data %04h last %b empty %b",
					$time, data, last, empty);
				return;
			end
			want = items_due.pop_front();
			if (data[7:0] !== want.ch) begin
				errors++;
				$display("%0t: line_char expected %02h actual %02h", $time, want.ch, data[7:0]);
			end
			if (data[13:8] !== want.len) begin
				errors++;
				$display("%0t: line_length expected %0d actual %0d", $time, want.len, data[13:8]);
			end
			if (data[rle_pkg::TDATA_W-1:14] !== '0) begin
				errors++;
				$display("%0t: tdata padding expected 0 actual %0h", $time,
					data[rle_pkg::TDATA_W-1:14]);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last_of_line expected %b actual %b", $time, want.last, last);
			end
			if (empty !== want.empty) begin
				errors++;
				$display("%0t: empty_line expected %b actual %b", $time, want.empty, empty);
			end
		endfunction

		function int unsigned pending();
			return items_due.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [rle_pkg::TDATA_W-1:0]   m_axis_tdata;
	logic                          m_axis_tlast;
	logic                          m_axis_tuser;

	console_line_scoreboard sb = new();

	int unsigned working_items = 0;
	int unsigned idle_cycles   = 0;
	bit          quiet_phase   = 1'b0;
	bit          held_off      = 1'b0;
	bit          calm_tx       = 1'b0;
	bit          calm_rx       = 1'b0;

	rx_line_editor_core #(
		.LINE_CAPACITY(LINE_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// monitors on both streams
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.take_rx_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_line_item(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("rx_line_editor_core_tb failed");
			$finish;
		end
	end

	task automatic send_rx_byte(input logic [7:0] c);
		int unsigned gap;
		if (!quiet_phase && !calm_tx && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		working_items++;
		if (working_items >= QUIET_AFTER)
			quiet_phase = 1'b1;
	endtask

	function automatic logic [7:0] pick_line_char();
		int unsigned idx;
		idx = $urandom_range(0, 66);
		if (idx < 26)
			return 8'(rle_pkg::CH_UA + idx);
		if (idx < 52)
			return 8'(rle_pkg::CH_LA + (idx - 26));
		if (idx < 62)
			return 8'(rle_pkg::CH_0 + (idx - 52));
		case (idx)
			62:      return rle_pkg::CH_SPACE;
			63:      return rle_pkg::CH_DOT;
			64:      return rle_pkg::CH_PLUS;
			65:      return rle_pkg::CH_MINUS;
			default: return rle_pkg::CH_COLON;
		endcase
	endfunction

	task automatic send_random_line(input int unsigned len);
		int unsigned r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				send_rx_byte(rle_pkg::CH_BS);
			else if (r < 4)
				send_rx_byte(8'($urandom_range(0, 255)));
			else
				send_rx_byte(pick_line_char());
		end
		send_rx_byte(rle_pkg::CH_CR);
	endtask

	task automatic send_full_line();
		for (int i = 0; i < LINE_MAX + 4; i++)
			send_rx_byte(pick_line_char());
		send_rx_byte(rle_pkg::CH_BS);
		send_rx_byte(pick_line_char());
		send_rx_byte(pick_line_char());
		send_rx_byte(rle_pkg::CH_CR);
	endtask

	// receiver side, with one long hold-off while input keeps coming
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!held_off && working_items >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet_phase && !calm_rx && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				calm_rx = !calm_rx;
		end
	end

	initial begin
		logic [7:0] opening [$];
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line, backspace on empty, ignored bytes, class edges
		opening = '{rle_pkg::CH_CR, rle_pkg::CH_BS, 8'h00, 8'hFF, 8'h80, 8'h7F,
			rle_pkg::CH_UA, rle_pkg::CH_UZ, rle_pkg::CH_LA, rle_pkg::CH_LZ,
			rle_pkg::CH_0, rle_pkg::CH_9,
			rle_pkg::CH_SPACE, rle_pkg::CH_DOT, rle_pkg::CH_PLUS,
			rle_pkg::CH_MINUS, rle_pkg::CH_COLON,
			8'h2F, 8'h3B, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2C,
			rle_pkg::CH_BS, rle_pkg::CH_CR};
		foreach (opening[i])
			send_rx_byte(opening[i]);

		send_full_line();
		while (working_items < ITEM_TARGET) begin
			calm_tx = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0:       send_full_line();
				1, 2:    send_random_line($urandom_range(30, 70));
				3:       send_random_line(0);
				default: send_random_line($urandom_range(1, 8));
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("rx_line_editor_core_tb passed");
		else
			$display("rx_line_editor_core_tb failed");
		$finish;
	end

endmodule
